@@ hw/rtl/rlbe_pkg.sv @@
// Shared types, constants and byte-selection helpers for the run-length byte encoder.
package rlbe_pkg;

    typedef logic [7:0] data_t;
    typedef logic [3:0] len_t;
    typedef logic [1:0] pos_t;

    // Longest chunk emitted in one go
    localparam len_t  MAX_CHUNK    = 4'd10;
    localparam data_t MARKER_RESET = 8'd36;
    localparam data_t DIGIT_BASE   = 8'h30;

    // One accepted input reduced to at most two chunks: a flushed old run, then a new one
    typedef struct packed {
        data_t a_val;
        len_t  a_len;
        data_t b_val;
        len_t  b_len;
        logic  fin;
    } cmd_t;

    // Output beats a chunk expands to
    function automatic pos_t chunk_count(input len_t len);
        pos_t n;
        n = (len >= 4'd3) ? 2'd3 : len[1:0];
        return n;
    endfunction

    // Byte at a given position of a chunk's encoding
    function automatic data_t chunk_byte(input data_t val, input len_t len, input pos_t pos,
                                         input data_t marker);
        data_t r;
        case (pos)
            2'd0:    r = val;
            2'd1:    r = (len == 4'd2) ? val : marker;
            2'd2:    r = DIGIT_BASE + {4'd0, len - 4'd1};
            default: r = val;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/rlbe_front.sv @@
// Front end: accepts input beats, tracks the pending run and emits chunk commands.
module rlbe_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_final,
    input  logic          q_full,
    output logic          q_push,
    output rlbe_pkg::cmd_t q_cmd
);

    rlbe_pkg::data_t val_reg, val_next;
    rlbe_pkg::len_t  len_reg, len_next;

    logic            accept;
    logic            flush_old;
    rlbe_pkg::len_t  base_len;
    rlbe_pkg::len_t  inc_len;
    rlbe_pkg::data_t new_val;
    logic            full_chunk;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        flush_old  = (len_reg != 4'd0) && (in_byte != val_reg);
        base_len   = flush_old ? 4'd0 : len_reg;
        new_val    = (base_len == 4'd0) ? in_byte : val_reg;
        inc_len    = base_len + 4'd1;
        full_chunk = (inc_len >= rlbe_pkg::MAX_CHUNK);

        q_cmd.a_val = val_reg;
        q_cmd.a_len = flush_old ? len_reg : 4'd0;
        q_cmd.b_val = new_val;
        q_cmd.b_len = (full_chunk || in_final) ? inc_len : 4'd0;
        q_cmd.fin   = in_final;

        q_push = accept && ((q_cmd.a_len != 4'd0) || (q_cmd.b_len != 4'd0));

        len_next = len_reg;
        val_next = val_reg;
        if (accept) begin
            len_next = (full_chunk || in_final) ? 4'd0 : inc_len;
            val_next = in_final ? 8'd0 : new_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 4'd0;
            val_reg <= 8'd0;
        end else begin
            len_reg <= len_next;
            val_reg <= val_next;
        end
    end

    a_len_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg < rlbe_pkg::MAX_CHUNK)
        else $error("pending run length reached the chunk limit");

    a_fin_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_final) |=> (len_reg == 4'd0) && (val_reg == 8'd0))
        else $error("run state not cleared after end of stream");

endmodule

@@ hw/rtl/rlbe_fifo.sv @@
// Short command queue between the front and back ends.
module rlbe_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rlbe_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rlbe_pkg::cmd_t head_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    rlbe_pkg::cmd_t slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy beyond depth");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

@@ hw/rtl/rlbe_back.sv @@
// Back end: expands queued chunk commands into output beats through an output register.
module rlbe_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     marker,
    input  logic           q_valid,
    input  rlbe_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     out_byte,
    output logic           out_run_done,
    output logic           out_stream_done
);

    rlbe_pkg::pos_t  idx_reg, idx_next;
    logic            m_valid_reg, m_valid_next;
    rlbe_pkg::data_t byte_reg;
    logic            run_done_reg;
    logic            stream_done_reg;

    rlbe_pkg::pos_t  na, nb;
    logic [2:0]      total;
    logic            in_a;
    rlbe_pkg::pos_t  pos;
    rlbe_pkg::data_t cur_byte;
    logic            last;
    logic            load;

    always_comb begin
        na    = rlbe_pkg::chunk_count(q_cmd.a_len);
        nb    = rlbe_pkg::chunk_count(q_cmd.b_len);
        total = {1'b0, na} + {1'b0, nb};
        in_a  = (idx_reg < na);
        pos   = in_a ? idx_reg : idx_reg - na;
        cur_byte = in_a ? rlbe_pkg::chunk_byte(q_cmd.a_val, q_cmd.a_len, pos, marker)
                        : rlbe_pkg::chunk_byte(q_cmd.b_val, q_cmd.b_len, pos, marker);
        last  = ({1'b0, idx_reg} == total - 3'd1);
        load  = q_valid && (!m_valid_reg || m_ready);
        q_pop = load && last;

        idx_next = idx_reg;
        if (load) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg        <= cur_byte;
            run_done_reg    <= last;
            stream_done_reg <= last && q_cmd.fin;
        end
    end

    assign m_valid         = m_valid_reg;
    assign out_byte        = byte_reg;
    assign out_run_done    = run_done_reg;
    assign out_stream_done = stream_done_reg;

    a_idx_in_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> ({1'b0, idx_reg} < total))
        else $error("expansion index beyond command length");

    a_stream_implies_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && stream_done_reg) |-> run_done_reg)
        else $error("stream end flagged on a beat that does not close its item");

endmodule

@@ hw/rtl/run_length_byte_encoder_top.sv @@
// Top level of the run-length byte encoder with escape marker.
// Accepts one source byte per cycle while the command queue (QUEUE_DEPTH entries) has room;
// each byte yields zero to four compressed bytes, delivered one per cycle from the output
// register while m_ready is high, so sustained throughput is one input per cycle on plain
// data and falls when runs are flushed. Through an empty queue the first result of a byte
// passes the queue slot and then the output register. marker_byte resets to 0x24 and is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce; no clearing pass follows reset.
module run_length_byte_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_run_done,
    output logic       m_out_stream_done
);

    rlbe_pkg::data_t marker_reg;
    rlbe_pkg::cmd_t  push_cmd;
    rlbe_pkg::cmd_t  head_cmd;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= rlbe_pkg::MARKER_RESET;
        end else if (cfg_wr_en) begin
            marker_reg <= cfg_wr_data;
        end
    end

    rlbe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .in_byte  (s_in_byte),
        .in_final (s_in_final),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    rlbe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rlbe_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .marker          (marker_reg),
        .q_valid         (head_valid),
        .q_cmd           (head_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .out_byte        (m_out_byte),
        .out_run_done    (m_out_run_done),
        .out_stream_done (m_out_stream_done)
    );

endmodule

@@ tb/sv/rlbe_stream_checker.sv @@
// Checker for the run-length byte encoder: predicts the compressed stream and compares each beat.
`timescale 1ns / 100ps

module rlbe_stream_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_final,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_out_run_done,
    input  logic       m_out_stream_done,
    output int         errors,
    output int         outstanding
);

    typedef struct packed {
        rlbe_pkg::data_t value;
        logic            run_done;
        logic            stream_done;
    } enc_beat_t;

    enc_beat_t       expected_beats[$];
    rlbe_pkg::data_t marker;
    rlbe_pkg::data_t run_val;
    rlbe_pkg::len_t  run_len;

    initial begin
        errors      = 0;
        outstanding = 0;
        marker      = rlbe_pkg::MARKER_RESET;
        run_val     = '0;
        run_len     = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic void push_beat(input rlbe_pkg::data_t v);
        enc_beat_t b;
        b.value       = v;
        b.run_done    = 1'b0;
        b.stream_done = 1'b0;
        expected_beats.push_back(b);
    endfunction

    // Expand one chunk into its compressed bytes
    function automatic void add_chunk(input rlbe_pkg::data_t v, input rlbe_pkg::len_t n);
        if (n == 0) return;
        push_beat(v);
        if (n == 2) begin
            push_beat(v);
        end else if (n >= 3) begin
            push_beat(marker);
            push_beat(rlbe_pkg::DIGIT_BASE + 8'(n - 1));
        end
    endfunction

    function automatic void predict_encoding(input rlbe_pkg::data_t b, input logic fin);
        int        first;
        enc_beat_t last;
        first = expected_beats.size();
        if (run_len != 0 && b != run_val) begin
            add_chunk(run_val, run_len);
            run_len = '0;
        end
        if (run_len == 0) run_val = b;
        run_len = run_len + 1'b1;
        if (run_len >= rlbe_pkg::MAX_CHUNK) begin
            add_chunk(run_val, run_len);
            run_len = '0;
        end
        if (fin) begin
            add_chunk(run_val, run_len);
            run_len = '0;
            run_val = '0;
        end
        // flag the last beat caused by this input
        if (expected_beats.size() > first) begin
            last             = expected_beats.pop_back();
            last.run_done    = 1'b1;
            last.stream_done = fin;
            expected_beats.push_back(last);
        end
    endfunction

    always @(posedge aclk) begin
        enc_beat_t want;
        if (!aresetn) begin
            marker  = rlbe_pkg::MARKER_RESET;
            run_val = '0;
            run_len = '0;
            expected_beats.delete();
        end else begin
            if (cfg_wr_en) marker = cfg_wr_data;
            // compare output first: a beat can never stem from an input taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte=%02h", m_out_byte));
                end else begin
                    want = expected_beats.pop_front();
                    if (m_out_byte !== want.value)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  m_out_byte, want.value));
                    if (m_out_run_done !== want.run_done)
                        report_mismatch($sformatf("out_run_done %b, want %b (byte %02h)",
                                                  m_out_run_done, want.run_done, want.value));
                    if (m_out_stream_done !== want.stream_done)
                        report_mismatch($sformatf("out_stream_done %b, want %b (byte %02h)",
                                                  m_out_stream_done, want.stream_done,
                                                  want.value));
                end
            end
            if (s_valid && s_ready) predict_encoding(s_in_byte, s_in_final);
        end
        outstanding = expected_beats.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Stimulus and verdict for the run-length byte encoder regression.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 72;
    localparam int NUM_PHASES   = 5;

    logic            aclk;
    logic            aresetn;
    logic            cfg_wr_en;
    logic [7:0]      cfg_wr_data;
    logic            s_valid;
    logic            s_ready;
    logic [7:0]      s_in_byte;
    logic            s_in_final;
    logic            m_valid;
    logic            m_ready;
    logic [7:0]      m_out_byte;
    logic            m_out_run_done;
    logic            m_out_stream_done;

    int              errors;
    int              outstanding;
    int              cycle_count;
    int              phase_count;
    logic            steady;
    logic            last_fin;
    rlbe_pkg::data_t cur_marker;

    run_length_byte_encoder_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_in_final        (s_in_final),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_out_run_done    (m_out_run_done),
        .m_out_stream_done (m_out_stream_done)
    );

    rlbe_stream_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_in_final        (s_in_final),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_out_run_done    (m_out_run_done),
        .m_out_stream_done (m_out_stream_done),
        .errors            (errors),
        .outstanding       (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_in_byte   = '0;
        s_in_final  = 1'b0;
        m_ready     = 1'b0;
        steady      = 1'b0;
        last_fin    = 1'b1;
        cycle_count = 0;
        phase_count = 0;
        cur_marker  = rlbe_pkg::MARKER_RESET;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sink back-pressure; none while a steady stretch runs
    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 25);
    end

    // Offer one beat from a falling edge and hold it until taken
    task automatic send_byte(input rlbe_pkg::data_t b, input logic fin);
        while (!steady && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_byte  <= b;
        s_in_final <= fin;
        phase_count++;
        last_fin = fin;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_run(input rlbe_pkg::data_t v, input int len, input logic fin_at_end);
        for (int i = 0; i < len; i++) send_byte(v, fin_at_end && (i == len - 1));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        // a pending run may still sit in the block with no beat expected
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_marker(input rlbe_pkg::data_t v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_marker = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic rlbe_pkg::data_t pick_run_value();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return cur_marker;
        if (sel == 1) return rlbe_pkg::DIGIT_BASE + 8'($urandom_range(9));
        if (sel < 5)  return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic int pick_run_len();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return $urandom_range(1, 4);
        if (sel < 9) return $urandom_range(5, 11);
        return $urandom_range(12, 25);
    endfunction

    // Mostly whole streams of runs; the rest loose bytes that end a stream at random
    task automatic run_phase();
        int runs;
        phase_count = 0;
        while (phase_count < PHASE_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                runs = $urandom_range(1, 6);
                for (int r = 0; r < runs; r++)
                    send_run(pick_run_value(), pick_run_len(),
                             (r == runs - 1) && ($urandom_range(3) != 0));
            end else begin
                repeat ($urandom_range(1, 8))
                    send_byte(pick_run_value(), $urandom_range(15) == 0);
            end
        end
        // close the stream so the next marker cannot land on a pending run
        if (!last_fin) send_byte(pick_run_value(), 1'b1);
    endtask

    initial begin
        rlbe_pkg::data_t marker_plan [NUM_PHASES];
        marker_plan[0] = rlbe_pkg::MARKER_RESET;
        marker_plan[1] = 8'h00;
        marker_plan[2] = 8'hFF;
        marker_plan[3] = 8'($urandom_range(255));
        marker_plan[4] = 8'($urandom_range(255));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: single byte, pair, literal marker run flushed by a new byte,
        // full chunk ending the stream, literal digits
        send_run(8'h00, 1, 1'b1);
        send_run(8'hFF, 2, 1'b1);
        send_run(8'h24, 3, 1'b0);
        send_run(8'h31, 1, 1'b1);
        send_run(8'hAA, 10, 1'b1);
        send_byte(8'h30, 1'b0);
        send_run(8'h39, 2, 1'b0);
        send_byte(8'h30, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) write_marker(marker_plan[p]);
            steady = (p == 2);
            run_phase();
        end
        steady = 1'b0;

        wait_drained();
        repeat (8) @(negedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
